// File: sv/sha256_byte_stream_hasher_unit_assert.svh
// Assertion macros for the SHA-256 hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sha256bsh_pkg.sv
// Shared types, round constants and round functions for the SHA-256 hasher.
package sha256bsh_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// One packed big-endian message word on its way to the compression unit.
	typedef struct packed {
		logic        msg_end;
		logic [31:0] word;
	} q_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MARK,
		F_ZERO,
		F_LEN
	} front_state_t;

	typedef enum logic [1:0] {
		B_ROUND,
		B_ADD,
		B_OUT
	} back_state_t;

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
		logic [63:0] dbl;
		dbl = {x, x} >> s;
		return dbl[31:0];
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// File: sv/sha256bsh_front.sv
// Front end: takes message bytes, appends padding and length, packs 32-bit words.
module sha256bsh_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] data_byte
	input  logic                     s_tuser,   // [0] byte_present
	input  logic                     s_tlast,
	input  logic                     q_full,
	output logic                     q_push,
	output sha256bsh_pkg::q_entry_t  q_wdata
);

	sha256bsh_pkg::front_state_t state_q, state_d;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [23:0] acc_q;
	logic        s_acc;
	logic        byte_vld;
	logic [7:0]  byte_val;
	logic [63:0] len_bits;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;

	// Length field, most significant byte first
	assign len_bits = {count_q, 3'b000};
	assign len_sel  = 3'd7 - fill_q[2:0];
	assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256bsh_pkg::F_IDLE: begin
				if (s_acc && s_tlast) state_d = sha256bsh_pkg::F_MARK;
			end
			sha256bsh_pkg::F_MARK: begin
				if (!q_full) state_d = sha256bsh_pkg::F_ZERO;
			end
			sha256bsh_pkg::F_ZERO: begin
				if (!q_full && fill_q == 6'd56) state_d = sha256bsh_pkg::F_LEN;
			end
			sha256bsh_pkg::F_LEN: begin
				if (!q_full && fill_q == 6'd63) state_d = sha256bsh_pkg::F_IDLE;
			end
			default: state_d = sha256bsh_pkg::F_IDLE;
		endcase
	end

	// Byte source: input stream, pad mark, zeros or length bytes
	always_comb begin
		s_tready = 1'b0;
		byte_vld = 1'b0;
		byte_val = 8'h00;
		case (state_q)
			sha256bsh_pkg::F_IDLE: begin
				s_tready = !q_full;
				byte_vld = s_tvalid && !q_full && s_tuser;
				byte_val = s_tdata;
			end
			sha256bsh_pkg::F_MARK: begin
				byte_vld = !q_full;
				byte_val = sha256bsh_pkg::PAD_MARK;
			end
			sha256bsh_pkg::F_ZERO: begin
				byte_vld = !q_full;
				byte_val = (fill_q == 6'd56) ? len_byte : 8'h00;
			end
			sha256bsh_pkg::F_LEN: begin
				byte_vld = !q_full;
				byte_val = len_byte;
			end
			default: begin
				byte_vld = 1'b0;
			end
		endcase
	end

	assign s_acc = s_tvalid && s_tready;

	// Word packing toward the queue
	assign q_push          = byte_vld && (fill_q[1:0] == 2'b11);
	assign q_wdata.word    = {acc_q, byte_val};
	assign q_wdata.msg_end = (state_q == sha256bsh_pkg::F_LEN) && (fill_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256bsh_pkg::F_IDLE;
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (byte_vld) fill_q <= fill_q + 6'd1;
			if (state_q == sha256bsh_pkg::F_IDLE && s_acc && s_tuser) begin
				count_q <= count_q + 61'd1;
			end else if (q_wdata.msg_end && byte_vld) begin
				count_q <= '0;
			end
		end
	end

	// Partial word holds the three earlier bytes
	always_ff @(posedge clk) begin
		if (byte_vld) acc_q <= {acc_q[15:0], byte_val};
	end

endmodule

// File: sv/sha256bsh_queue.sv
// Short word queue between the front end and the compression unit.
module sha256bsh_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  sha256bsh_pkg::q_entry_t  wdata,
	input  logic                     pop,
	output sha256bsh_pkg::q_entry_t  rdata,
	output logic                     full,
	output logic                     empty
);

	sha256bsh_pkg::q_entry_t mem_q [sha256bsh_pkg::QDEPTH];
	logic [sha256bsh_pkg::QAW-1:0] wr_ptr_q;
	logic [sha256bsh_pkg::QAW-1:0] rd_ptr_q;
	logic [sha256bsh_pkg::QAW:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign full    = cnt_q == (sha256bsh_pkg::QAW+1)'(sha256bsh_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: sv/sha256bsh_back.sv
// Compression unit: one SHA-256 round per cycle unless a round waits on an empty queue, hash update and digest output.
module sha256bsh_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha256bsh_pkg::q_entry_t  q_rdata,
	input  logic                     q_empty,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,   // [31:0] digest_word
	output logic [2:0]               m_tuser,   // [2:0] word_index
	output logic                     m_tlast
);

	sha256bsh_pkg::back_state_t state_q, state_d;
	logic [31:0] window_q [16];
	logic [31:0] v_q [8];
	logic [31:0] hash_q [8];
	logic [31:0] hsum [8];
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        end_q;
	logic        need_word;
	logic        step;
	logic        do_add;
	logic        out_fire;
	logic [31:0] w_sched;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;

	// Message schedule and round function
	assign need_word = round_q[5:4] == 2'b00;
	assign w_sched   = window_q[0] + sha256bsh_pkg::ssig0(window_q[1]) + window_q[9]
		+ sha256bsh_pkg::ssig1(window_q[14]);
	assign w_cur     = need_word ? q_rdata.word : w_sched;
	assign t1 = v_q[7] + sha256bsh_pkg::bsig1(v_q[4])
		+ sha256bsh_pkg::ch(v_q[4], v_q[5], v_q[6]) + sha256bsh_pkg::K[round_q] + w_cur;
	assign t2 = sha256bsh_pkg::bsig0(v_q[0]) + sha256bsh_pkg::maj(v_q[0], v_q[1], v_q[2]);

	always_comb begin
		for (int j = 0; j < 8; j++) hsum[j] = hash_q[j] + v_q[j];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256bsh_pkg::B_ROUND: begin
				if (step && round_q == 6'd63) state_d = sha256bsh_pkg::B_ADD;
			end
			sha256bsh_pkg::B_ADD: begin
				state_d = end_q ? sha256bsh_pkg::B_OUT : sha256bsh_pkg::B_ROUND;
			end
			sha256bsh_pkg::B_OUT: begin
				if (m_tready && idx_q == 3'd7) state_d = sha256bsh_pkg::B_ROUND;
			end
			default: state_d = sha256bsh_pkg::B_ROUND;
		endcase
	end

	// Control outputs
	always_comb begin
		step     = 1'b0;
		q_pop    = 1'b0;
		do_add   = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			sha256bsh_pkg::B_ROUND: begin
				step  = need_word ? !q_empty : 1'b1;
				q_pop = need_word && !q_empty;
			end
			sha256bsh_pkg::B_ADD: begin
				do_add = 1'b1;
			end
			sha256bsh_pkg::B_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				step = 1'b0;
			end
		endcase
	end

	assign out_fire = m_tvalid && m_tready;
	assign m_tdata  = hash_q[idx_q];
	assign m_tuser  = idx_q;
	assign m_tlast  = idx_q == 3'd7;

	// Control, working variables and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256bsh_pkg::B_ROUND;
			round_q <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			for (int j = 0; j < 8; j++) begin
				hash_q[j] <= sha256bsh_pkg::IV[j];
				v_q[j]    <= sha256bsh_pkg::IV[j];
			end
		end else begin
			state_q <= state_d;
			if (q_pop) end_q <= q_rdata.msg_end;
			if (step) begin
				round_q <= round_q + 6'd1;
				v_q[0]  <= t1 + t2;
				v_q[1]  <= v_q[0];
				v_q[2]  <= v_q[1];
				v_q[3]  <= v_q[2];
				v_q[4]  <= v_q[3] + t1;
				v_q[5]  <= v_q[4];
				v_q[6]  <= v_q[5];
				v_q[7]  <= v_q[6];
			end
			if (do_add) begin
				idx_q <= '0;
				for (int j = 0; j < 8; j++) begin
					hash_q[j] <= hsum[j];
					v_q[j]    <= hsum[j];
				end
			end
			// Digest drained: back to the initial hash for the next message
			if (out_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					for (int j = 0; j < 8; j++) begin
						hash_q[j] <= sha256bsh_pkg::IV[j];
						v_q[j]    <= sha256bsh_pkg::IV[j];
					end
				end
			end
		end
	end

	// Sixteen-word schedule window, oldest word at the bottom
	always_ff @(posedge clk) begin
		if (step) begin
			for (int j = 0; j < 15; j++) window_q[j] <= window_q[j+1];
			window_q[15] <= w_cur;
		end
	end

endmodule

// File: sv/sha256_byte_stream_hasher_unit.sv
// SHA-256 over a byte stream: one byte per request, eight digest words per message.
// Input: one byte per cycle while the four-word queue has room; a 64-byte block takes 64
// rounds and a hash add in the compression unit (one round per cycle, waits on an empty queue).
// End of message: input held off while the pad mark, zero bytes and length field are queued;
// digest valid once the final block's rounds and hash add are done, then 8 words.
// Reset (arst_n low, asynchronous): initial hash loaded, counters zero, queue empty.
module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);

	sha256bsh_pkg::q_entry_t q_wdata;
	sha256bsh_pkg::q_entry_t q_rdata;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	sha256bsh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	sha256bsh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	sha256bsh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: sv/sha256bsh_checker.sv
// Port-level checks on the digest output of the SHA-256 hasher, bound to the top level.
`include "sha256_byte_stream_hasher_unit_assert.svh"

module sha256bsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// Last word is exactly the one at index seven
	`SHA_ASSERT_SAME(a_last_idx, m_tvalid, m_tlast == (m_tuser == 3'd7), "tlast off index 7")

	// Digest words come back to back in index order
	`SHA_ASSERT_NEXT(a_idx_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1), "digest words out of order")

	// After the last word is taken, output valid must drop
	`SHA_ASSERT_NEXT(a_gap, m_tvalid && m_tready && m_tlast, !m_tvalid, "output after last word")

	// Stalled output request holds
	`SHA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")

endmodule

bind sha256_byte_stream_hasher_unit sha256bsh_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
